@@ design/rrs_pkg.sv @@
// Shared types, codes and constants for the ring round-robin scheduler.
`default_nettype none

package rrs_pkg;

    localparam int SLOTS_DEF = 16;

    localparam int ID_W     = 16;
    localparam int OP_W     = 3;
    localparam int RELOAD_W = 8;
    localparam int QUANT_W  = 9;

    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 8'd4;
    localparam logic [QUANT_W-1:0]  QUANT_MIN    = 9'h100;   // -256, saturation point

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_SETRUN = 3'd3;
    localparam logic [OP_W-1:0] OP_LOCK   = 3'd4;
    localparam logic [OP_W-1:0] OP_UNLOCK = 3'd5;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_DEFER    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_RD,
        S_ADD_LINK,
        S_ADD_STORE,
        S_SCAN_FREE,
        S_RING_PREP,
        S_RING_LOAD,
        S_RING_STEP,
        S_RD_CUR,
        S_RESP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    latch_in;
        logic    rd_follow;    // read address from last next pointer, else current slot
        logic    walk_mode;    // ring match on runnable, else on id
        logic    set_status;
        status_t status;
        logic    tick_dec;
        logic    set_pending;
        logic    clr_pending;
        logic    set_lock;
        logic    clr_lock;
        logic    ring_load;
        logic    ring_adv;
        logic    walk_hit;
        logic    walk_miss;
        logic    rm_hit;
        logic    run_hit;
        logic    add_empty;
        logic    add_link;
        logic    add_store;
        logic    scan_step;
        logic    out_load;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cnt_zero;
        logic            cnt_full;
        logic            cnt_one;
        logic            due;
        logic            locked;
        logic            pending;
        logic            ring_match;
        logic            ring_last;
        logic            hit_is_prev;
        logic            hit_is_cur;
        logic            scan_done;
        logic            out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ design/rrs_ctrl.sv @@
// Sequencing state machine of the ring round-robin scheduler.
`default_nettype none

module rrs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rrs_pkg::dp_stat_t  stat,
    output rrs_pkg::ctrl_cmd_t      cmd
);

    rrs_pkg::state_t state_reg;
    rrs_pkg::state_t state_next;
    logic            walk_mode_reg;
    logic            walk_mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrs_pkg::S_IDLE;
            walk_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_mode_reg <= walk_mode_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        walk_mode_next = walk_mode_reg;
        cmd            = '0;
        cmd.status     = rrs_pkg::ST_OK;
        cmd.walk_mode  = walk_mode_reg;
        in_ready       = 1'b0;

        unique case (state_reg)
            rrs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = rrs_pkg::S_DECODE;
                end
            end

            rrs_pkg::S_DECODE:
            begin
                state_next = rrs_pkg::S_RD_CUR;
                unique case (stat.op)
                    rrs_pkg::OP_TICK:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = rrs_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.tick_dec = 1'b1;
                            if (stat.due && stat.locked)
                            begin
                                cmd.set_pending = 1'b1;
                                cmd.set_status  = 1'b1;
                                cmd.status      = rrs_pkg::ST_DEFER;
                            end
                            else if (stat.due)
                            begin
                                walk_mode_next = 1'b1;
                                state_next     = rrs_pkg::S_RING_PREP;
                            end
                        end
                    end
                    rrs_pkg::OP_ADD:
                    begin
                        if (stat.cnt_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = rrs_pkg::ST_FULL;
                        end
                        else if (stat.cnt_zero)
                        begin
                            cmd.add_empty = 1'b1;
                            state_next    = rrs_pkg::S_SCAN_FREE;
                        end
                        else
                        begin
                            state_next = rrs_pkg::S_ADD_RD;
                        end
                    end
                    rrs_pkg::OP_REMOVE, rrs_pkg::OP_SETRUN:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = rrs_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            walk_mode_next = 1'b0;
                            state_next     = rrs_pkg::S_RING_PREP;
                        end
                    end
                    rrs_pkg::OP_LOCK:
                    begin
                        cmd.set_lock = 1'b1;
                    end
                    rrs_pkg::OP_UNLOCK:
                    begin
                        cmd.clr_lock = 1'b1;
                        if (stat.pending)
                        begin
                            cmd.clr_pending = 1'b1;
                            if (!stat.cnt_zero)
                            begin
                                walk_mode_next = 1'b1;
                                state_next     = rrs_pkg::S_RING_PREP;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = rrs_pkg::S_RD_CUR;
                    end
                endcase
            end

            rrs_pkg::S_ADD_RD:
            begin
                state_next = rrs_pkg::S_ADD_LINK;
            end

            rrs_pkg::S_ADD_LINK:
            begin
                cmd.add_link = 1'b1;
                state_next   = rrs_pkg::S_ADD_STORE;
            end

            rrs_pkg::S_ADD_STORE:
            begin
                cmd.add_store = 1'b1;
                state_next    = rrs_pkg::S_SCAN_FREE;
            end

            rrs_pkg::S_SCAN_FREE:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = rrs_pkg::S_RD_CUR;
                end
            end

            rrs_pkg::S_RING_PREP:
            begin
                state_next = rrs_pkg::S_RING_LOAD;
            end

            rrs_pkg::S_RING_LOAD:
            begin
                cmd.ring_load = 1'b1;
                cmd.rd_follow = 1'b1;
                state_next    = rrs_pkg::S_RING_STEP;
            end

            rrs_pkg::S_RING_STEP:
            begin
                state_next = rrs_pkg::S_RD_CUR;
                if (stat.ring_match && walk_mode_reg)
                begin
                    cmd.walk_hit = 1'b1;
                end
                else if (stat.ring_match && stat.op == rrs_pkg::OP_REMOVE)
                begin
                    cmd.rm_hit = 1'b1;
                    // freed slot was current: move on at once
                    if (!stat.hit_is_prev && stat.hit_is_cur && !stat.cnt_one)
                    begin
                        walk_mode_next = 1'b1;
                        state_next     = rrs_pkg::S_RING_PREP;
                    end
                end
                else if (stat.ring_match)
                begin
                    cmd.run_hit = 1'b1;
                end
                else if (stat.ring_last && walk_mode_reg)
                begin
                    cmd.walk_miss = 1'b1;
                end
                else if (stat.ring_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = rrs_pkg::ST_NOTFOUND;
                end
                else
                begin
                    cmd.ring_adv  = 1'b1;
                    cmd.rd_follow = 1'b1;
                    state_next    = rrs_pkg::S_RING_STEP;
                end
            end

            rrs_pkg::S_RD_CUR:
            begin
                state_next = rrs_pkg::S_RESP;
            end

            rrs_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rrs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rrs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/rrs_datapath.sv @@
// Slot tables, ring memories, counters and output register of the scheduler.
`default_nettype none

module rrs_datapath #(
    parameter int SLOTS = rrs_pkg::SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [rrs_pkg::OP_W-1:0]      in_op,
    input  wire logic [rrs_pkg::ID_W-1:0]      in_id,
    input  wire logic                          in_run,
    input  wire logic                          cfg_we,
    input  wire logic [rrs_pkg::RELOAD_W-1:0]  cfg_wdata,
    input  wire rrs_pkg::ctrl_cmd_t            cmd,
    output rrs_pkg::dp_stat_t                  stat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2:0]                         out_status,
    output logic [rrs_pkg::ID_W-1:0]           out_id,
    output logic                               out_cvalid,
    output logic                               out_switched
);

    localparam int IDXW = $clog2(SLOTS);
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam logic [IDXW:0]   SLOTS_IX  = (IDXW + 1)'(SLOTS);
    localparam logic [CNTW-1:0] SLOTS_CNT = CNTW'(SLOTS);

    function automatic logic [IDXW-1:0] slot_ix(input logic [IDXW-1:0] x);
        return ({1'b0, x} < SLOTS_IX) ? x : '0;
    endfunction

    // latched item
    logic [rrs_pkg::OP_W-1:0]     op_reg;
    logic [rrs_pkg::ID_W-1:0]     id_reg;
    logic                         run_in_reg;

    logic [rrs_pkg::RELOAD_W-1:0] reload_reg;
    logic [rrs_pkg::QUANT_W-1:0]  quant_reg;   // two's complement
    logic                         locked_reg;
    logic                         pending_reg;
    logic [IDXW-1:0]              cur_reg;
    logic [CNTW-1:0]              count_reg;
    logic [CNTW-1:0]              lowfree_reg;
    logic [SLOTS-1:0]             used_reg;
    logic [SLOTS-1:0]             runf_reg;

    // ring traversal
    logic [IDXW-1:0]              t_reg;
    logic [IDXW-1:0]              p_reg;
    logic [IDXW-1:0]              first_reg;
    logic [CNTW-1:0]              step_reg;
    logic [CNTW-1:0]              scan_reg;

    rrs_pkg::status_t             status_reg;
    logic                         sw_reg;

    logic                         out_valid_reg;
    logic [2:0]                   out_status_reg;
    logic [rrs_pkg::ID_W-1:0]     out_id_reg;
    logic                         out_cvalid_reg;
    logic                         out_sw_reg;

    // ring memories, no reset
    logic [IDXW-1:0]              next_mem [SLOTS];
    logic [rrs_pkg::ID_W-1:0]     id_mem   [SLOTS];
    logic [IDXW-1:0]              next_rd_reg;
    logic [rrs_pkg::ID_W-1:0]     id_rd_reg;

    logic [IDXW-1:0]              follow_ix;
    logic [IDXW-1:0]              free_ix;
    logic [IDXW-1:0]              rd_addr;
    logic                         ring_match;
    logic                         ring_last;
    logic                         scan_done;
    logic                         cnt_zero;

    logic                         nx_we;
    logic [IDXW-1:0]              nx_wa;
    logic [IDXW-1:0]              nx_wd;
    logic                         id_we;
    logic [IDXW-1:0]              id_wa;

    assign follow_ix = slot_ix(next_rd_reg);
    assign free_ix   = (lowfree_reg < SLOTS_CNT) ? lowfree_reg[IDXW-1:0] : '0;
    assign rd_addr   = cmd.rd_follow ? follow_ix : cur_reg;
    assign cnt_zero  = (count_reg == '0);

    assign ring_match = cmd.walk_mode ? (used_reg[t_reg] && runf_reg[t_reg])
                                      : (used_reg[t_reg] && id_rd_reg == id_reg);
    assign ring_last  = ((step_reg + CNTW'(1)) >= count_reg);
    assign scan_done  = (scan_reg >= SLOTS_CNT) || !used_reg[scan_reg[IDXW-1:0]];

    always_comb
    begin
        nx_we = 1'b0;
        nx_wa = cur_reg;
        nx_wd = next_rd_reg;
        priority if (cmd.add_empty)
        begin
            nx_we = 1'b1;
            nx_wa = '0;
            nx_wd = '0;
        end
        else if (cmd.add_link)
        begin
            nx_we = 1'b1;
            nx_wa = free_ix;
        end
        else if (cmd.add_store)
        begin
            nx_we = 1'b1;
            nx_wd = free_ix;
        end
        else if (cmd.rm_hit && t_reg != p_reg)
        begin
            nx_we = 1'b1;
            nx_wa = p_reg;
        end
        else
        begin
            nx_we = 1'b0;
        end
    end

    assign id_we = cmd.add_empty || cmd.add_store;
    assign id_wa = cmd.add_empty ? '0 : free_ix;

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        next_rd_reg <= next_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[id_wa] <= id_reg;
        end
        id_rd_reg <= id_mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg     <= in_op;
            id_reg     <= in_id;
            run_in_reg <= in_run;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_id_reg     <= cnt_zero ? '0 : id_rd_reg;
            out_cvalid_reg <= !cnt_zero;
            out_sw_reg     <= sw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg    <= rrs_pkg::RELOAD_RESET;
            quant_reg     <= {1'b0, rrs_pkg::RELOAD_RESET};
            locked_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            cur_reg       <= '0;
            count_reg     <= '0;
            lowfree_reg   <= '0;
            used_reg      <= '0;
            runf_reg      <= '0;
            t_reg         <= '0;
            p_reg         <= '0;
            first_reg     <= '0;
            step_reg      <= '0;
            scan_reg      <= '0;
            status_reg    <= rrs_pkg::ST_OK;
            sw_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                reload_reg <= cfg_wdata;
            end

            // reload after a walk wins over the tick decrement
            if (cmd.walk_hit || cmd.walk_miss)
            begin
                quant_reg <= {1'b0, reload_reg};
            end
            else if (cmd.tick_dec && quant_reg != rrs_pkg::QUANT_MIN)
            begin
                quant_reg <= quant_reg - rrs_pkg::QUANT_W'(1);
            end

            if (cmd.set_lock)
            begin
                locked_reg <= 1'b1;
            end
            else if (cmd.clr_lock)
            begin
                locked_reg <= 1'b0;
            end

            if (cmd.set_pending)
            begin
                pending_reg <= 1'b1;
            end
            else if (cmd.clr_pending)
            begin
                pending_reg <= 1'b0;
            end

            if (cmd.add_empty)
            begin
                cur_reg <= '0;
            end
            else if (cmd.walk_hit)
            begin
                cur_reg <= t_reg;
            end
            else if (cmd.walk_miss)
            begin
                cur_reg <= used_reg[cur_reg] ? cur_reg : first_reg;
            end
            else if (cmd.rm_hit && t_reg == p_reg)
            begin
                cur_reg <= '0;  // last task gone
            end

            if (cmd.add_empty || cmd.add_store)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            else if (cmd.rm_hit)
            begin
                count_reg <= count_reg - CNTW'(1);
            end

            if (cmd.scan_step && scan_done)
            begin
                lowfree_reg <= scan_reg;
            end
            else if (cmd.rm_hit && CNTW'(t_reg) < lowfree_reg)
            begin
                lowfree_reg <= CNTW'(t_reg);
            end

            if (cmd.add_empty)
            begin
                used_reg[0] <= 1'b1;
                runf_reg[0] <= 1'b1;
            end
            else if (cmd.add_store)
            begin
                used_reg[free_ix] <= 1'b1;
                runf_reg[free_ix] <= 1'b1;
            end
            else if (cmd.rm_hit)
            begin
                used_reg[t_reg] <= 1'b0;
                runf_reg[t_reg] <= 1'b0;
            end
            else if (cmd.run_hit)
            begin
                runf_reg[t_reg] <= run_in_reg;
            end

            if (cmd.ring_load)
            begin
                t_reg     <= follow_ix;
                p_reg     <= cur_reg;
                first_reg <= follow_ix;
                step_reg  <= '0;
            end
            else if (cmd.ring_adv)
            begin
                p_reg    <= t_reg;
                t_reg    <= follow_ix;
                step_reg <= step_reg + CNTW'(1);
            end

            // lowest free search starts at the slot just filled
            if (cmd.add_empty)
            begin
                scan_reg <= '0;
            end
            else if (cmd.add_store)
            begin
                scan_reg <= CNTW'(free_ix);
            end
            else if (cmd.scan_step && !scan_done)
            begin
                scan_reg <= scan_reg + CNTW'(1);
            end

            if (cmd.latch_in)
            begin
                status_reg <= rrs_pkg::ST_OK;
                sw_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.set_status)
                begin
                    status_reg <= cmd.status;
                end
                if (cmd.walk_hit || cmd.walk_miss)
                begin
                    sw_reg <= 1'b1;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.op          = op_reg;
    assign stat.cnt_zero    = cnt_zero;
    assign stat.cnt_full    = (count_reg >= SLOTS_CNT);
    assign stat.cnt_one     = (count_reg == CNTW'(1));
    assign stat.due         = quant_reg[rrs_pkg::QUANT_W-1];
    assign stat.locked      = locked_reg;
    assign stat.pending     = pending_reg;
    assign stat.ring_match  = ring_match;
    assign stat.ring_last   = ring_last;
    assign stat.hit_is_prev = (t_reg == p_reg);
    assign stat.hit_is_cur  = (t_reg == cur_reg);
    assign stat.scan_done   = scan_done;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_id       = out_id_reg;
    assign out_cvalid   = out_cvalid_reg;
    assign out_switched = out_sw_reg;

endmodule

`default_nettype wire

@@ design/ring_round_robin_scheduler.sv @@
// Top level of the ring round-robin scheduler: controller, datapath, assertions.
//
// Usage: each input word on the s_ side is one scheduler command (tick, add,
// remove, set runnable, lock, unlock) and produces exactly one result word on
// the m_ side carrying a status code, the current task id, whether any task
// is held and whether the command ran a round-robin switch.
// Commands are handled one at a time. A ring walk or id search visits at
// most as many slots as tasks are held, and a remove of the current task adds
// a second walk; an add scans for the next free slot, up to SLOTS of them.
// The run time is set by the ring traversal, one next pointer read per cycle
// from the link memory, and by the one-slot-per-cycle free-slot scan.
// s_tready is high whenever no command is in flight, also while a result
// waits in the output register; a stalled receiver holds the next result in
// the controller until the output register drains.
// Reset (rst_n low, async) empties the table, clears lock and pending switch,
// and sets the reload and the quantum to 4. The link and id memories have no
// reset and need no clearing pass. cfg_we writes quantum_reload;
// write it only while no command is in flight.
`default_nettype none

module ring_round_robin_scheduler #(
    parameter int SLOTS = rrs_pkg::SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,     // [15:0] task_id, [16] runnable, zero pad
    input  wire logic [2:0]  s_tuser,     // [2:0] op

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,     // [15:0] current_id, [16] current_valid,
                                          // [17] switched, zero pad
    output logic [2:0]       m_tuser,     // [2:0] status

    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata    // quantum_reload
);

    rrs_pkg::ctrl_cmd_t           cmd;
    rrs_pkg::dp_stat_t            stat;

    logic [rrs_pkg::ID_W-1:0]     out_id;
    logic                         out_cvalid;
    logic                         out_switched;

    rrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrs_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_op        (s_tuser),
        .in_id        (s_tdata[rrs_pkg::ID_W-1:0]),
        .in_run       (s_tdata[rrs_pkg::ID_W]),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (m_tuser),
        .out_id       (out_id),
        .out_cvalid   (out_cvalid),
        .out_switched (out_switched)
    );

    assign m_tdata = {6'b0, out_switched, out_cvalid, out_id};

    // --- assertions ---

    // one command in flight: accept takes the controller out of idle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while a command is in flight");

    // a switch always lands on a held task
    a_switch_has_task: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[17]) |-> m_tdata[16])
        else $error("switch reported with an empty table");

    // a deferred switch never walks the ring in the same command
    a_defer_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == rrs_pkg::ST_DEFER) |-> !m_tdata[17])
        else $error("deferred status with switched set");

    // a result is only loaded from the response state when the output can take it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over an unsent result");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the ring round-robin scheduler: directed table, random bursts.
`timescale 1ns / 100ps

module tb_top;

    import rrs_pkg::*;

    // Op codes 6 and 7 are unused by the block: status ok, nothing changes.
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int N_SLOTS     = SLOTS_DEF;
    localparam int PLAN_ROWS   = 25;
    localparam int PHASE_WORDS = 115;   // random words per phase, bursts may overshoot
    localparam int LAST_PHASE  = 5;
    localparam int HOLD_CYCLES = 300;   // long receiver stall, fills the block
    localparam int SHOW_ERRORS = 10;

    // One result word as the block reports it.
    typedef struct packed {
        status_t     status;
        logic [15:0] cur_id;
        logic        cur_valid;
        logic        switched;
    } reply_t;

    // One command word plus how the testbench treats it.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [15:0]     id;
        logic            run;
        logic            pick_held;   // id is taken from a held task when sent
        logic            typed;       // want holds a hand-written expectation
        reply_t          want;
    } cmd_t;

    typedef enum {
        BURST_MIXED,
        BURST_FILL,
        BURST_DRAIN,
        BURST_LOCKED,
        BURST_NOISE,
        BURST_SATURATE
    } burst_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. All inputs start at a known value.
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;     // [15:0] task_id, [16] runnable, zero pad
    logic [2:0]  s_tuser   = '0;     // [2:0] op
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;            // [15:0] current_id, [16] current_valid, [17] switched
    logic [2:0]  m_tuser;            // [2:0] status
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = '0;     // quantum_reload

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    ring_round_robin_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Scheduler shadow: own copy of the ring, the slots and the quantum.
    // Updated only in the sending process, at the edge a word is taken.
    // ------------------------------------------------------------------
    logic [3:0]        ring_next  [N_SLOTS];
    logic [15:0]       slot_task  [N_SLOTS];
    logic              slot_busy  [N_SLOTS];
    logic              slot_ready [N_SLOTS];
    logic [3:0]        cur_slot;
    logic [4:0]        held_count;
    logic [4:0]        free_slot;
    logic signed [8:0] quantum;
    logic              is_locked;
    logic              switch_owed;
    logic [7:0]        reload_val;

    reply_t expected_q [$];
    cmd_t   cmd_q [$];
    cmd_t   directed_plan [PLAN_ROWS];
    logic [15:0] id_pool [6];

    int send_gap_pct = 32;
    int recv_gap_pct = 64;
    bit hold_req     = 1'b0;
    int hold_left    = 0;

    int words_sent   = 0;
    int words_seen   = 0;
    int error_count  = 0;
    int n_switch     = 0;
    int n_full       = 0;
    int n_defer      = 0;
    int n_notfound   = 0;
    int n_empty      = 0;

    function automatic logic [4:0] lowest_unused();
        for (int i = 0; i < N_SLOTS; i++)
            if (!slot_busy[i])
                return 5'(i);
        return 5'(N_SLOTS);
    endfunction

    // Round-robin step: first runnable successor, else stay (or leave a freed slot).
    task automatic rotate_current();
        logic [3:0] start;
        logic [3:0] t;
        bit         found;
        start = cur_slot;
        t     = start;
        found = 1'b0;
        for (int i = 0; i < held_count && !found; i++)
        begin
            t = ring_next[t];
            if (slot_busy[t] && slot_ready[t])
            begin
                cur_slot = t;
                found    = 1'b1;
            end
        end
        if (!found)
            cur_slot = slot_busy[start] ? start : ring_next[start];
        quantum = $signed({1'b0, reload_val});
    endtask

    // Id search from the successor of current; first match round the ring wins.
    function automatic bit locate_task(input logic [15:0] id,
                                       output logic [3:0] prev, output logic [3:0] hit);
        logic [3:0] p;
        logic [3:0] t;
        p    = cur_slot;
        t    = ring_next[p];
        prev = '0;
        hit  = '0;
        for (int i = 0; i < held_count; i++)
        begin
            if (slot_busy[t] && slot_task[t] == id)
            begin
                prev = p;
                hit  = t;
                return 1'b1;
            end
            p = t;
            t = ring_next[t];
        end
        return 1'b0;
    endfunction

    task automatic schedule_step(input logic [OP_W-1:0] op, input logic [15:0] id,
                                 input logic run, output reply_t res);
        status_t    st;
        logic       sw;
        logic       due;
        logic [3:0] s;
        logic [3:0] prev;
        logic [3:0] hit;
        st = ST_OK;
        sw = 1'b0;
        case (op)
            OP_TICK:
            begin
                if (held_count == 0)
                    st = ST_EMPTY;
                else
                begin
                    due = (quantum < 0);
                    if (quantum != QUANT_MIN)
                        quantum = quantum - 9'sd1;
                    if (due)
                    begin
                        if (is_locked)
                        begin
                            switch_owed = 1'b1;
                            st          = ST_DEFER;
                        end
                        else
                        begin
                            rotate_current();
                            sw = 1'b1;
                        end
                    end
                end
            end
            OP_ADD:
            begin
                if (held_count >= N_SLOTS)
                    st = ST_FULL;
                else
                begin
                    if (held_count == 0)
                    begin
                        s            = '0;
                        cur_slot     = '0;
                        ring_next[0] = '0;
                    end
                    else
                    begin
                        s                   = free_slot[3:0];
                        ring_next[s]        = ring_next[cur_slot];
                        ring_next[cur_slot] = s;
                    end
                    slot_task[s]  = id;
                    slot_busy[s]  = 1'b1;
                    slot_ready[s] = 1'b1;
                    held_count    = held_count + 5'd1;
                    free_slot     = lowest_unused();
                end
            end
            OP_REMOVE:
            begin
                if (held_count == 0)
                    st = ST_EMPTY;
                else if (!locate_task(id, prev, hit))
                    st = ST_NOTFOUND;
                else
                begin
                    slot_busy[hit]  = 1'b0;
                    slot_ready[hit] = 1'b0;
                    held_count      = held_count - 5'd1;
                    if ({1'b0, hit} < free_slot)
                        free_slot = {1'b0, hit};
                    if (hit == prev)
                        cur_slot = '0;               // last task gone
                    else
                    begin
                        ring_next[prev] = ring_next[hit];
                        // current freed among several: move on at once, lock or not
                        if (hit == cur_slot && held_count > 0)
                        begin
                            rotate_current();
                            sw = 1'b1;
                        end
                    end
                end
            end
            OP_SETRUN:
            begin
                if (held_count == 0)
                    st = ST_EMPTY;
                else if (!locate_task(id, prev, hit))
                    st = ST_NOTFOUND;
                else
                    slot_ready[hit] = run;
            end
            OP_LOCK:
                is_locked = 1'b1;
            OP_UNLOCK:
            begin
                is_locked = 1'b0;
                if (switch_owed)
                begin
                    switch_owed = 1'b0;
                    if (held_count > 0)
                    begin
                        rotate_current();
                        sw = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.status    = st;
        res.cur_id    = (held_count > 0) ? slot_task[cur_slot] : 16'h0000;
        res.cur_valid = (held_count > 0);
        res.switched  = sw;
        n_switch   += sw;
        n_full     += (st == ST_FULL);
        n_defer    += (st == ST_DEFER);
        n_notfound += (st == ST_NOTFOUND);
        n_empty    += (st == ST_EMPTY);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic cmd_t make_cmd(input logic [OP_W-1:0] op, input logic [15:0] id,
                                      input logic run, input logic pick);
        cmd_t c;
        c           = '0;
        c.op        = op;
        c.id        = id;
        c.run       = run;
        c.pick_held = pick;
        return c;
    endfunction

    // Id of a task now held; leans toward the current one so removes hit it.
    function automatic logic [15:0] held_task_id();
        int unsigned k;
        if (held_count == 0)
            return 16'($urandom);
        if ($urandom_range(9) < 3)
            return slot_task[cur_slot];
        do
            k = $urandom_range(N_SLOTS - 1);
        while (!slot_busy[k]);
        return slot_task[k];
    endfunction

    // Small pool gives duplicate ids; the rest spreads over all 16 bits.
    function automatic logic [15:0] fresh_id();
        if ($urandom_range(1))
            return id_pool[$urandom_range(5)];
        return 16'($urandom);
    endfunction

    function automatic logic [OP_W-1:0] mixed_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) return OP_TICK;
        if (r < 55) return OP_ADD;
        if (r < 67) return OP_REMOVE;
        if (r < 82) return OP_SETRUN;
        if (r < 89) return OP_LOCK;
        if (r < 96) return OP_UNLOCK;
        return $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
    endfunction

    function automatic cmd_t mixed_cmd();
        logic [OP_W-1:0] op;
        op = mixed_op();
        if (op == OP_ADD)
            return make_cmd(op, fresh_id(), 1'($urandom), 1'b0);
        if (op == OP_REMOVE || op == OP_SETRUN)
            return make_cmd(op, 16'($urandom), 1'($urandom), $urandom_range(3) != 0);
        return make_cmd(op, 16'($urandom), 1'($urandom), 1'b0);
    endfunction

    task automatic build_burst(input burst_t kind);
        int n;
        case (kind)
            BURST_FILL:     // enough adds to run into a full table
                for (int i = 0; i < 18; i++)
                    cmd_q.push_back(make_cmd(OP_ADD, fresh_id(), 1'($urandom), 1'b0));
            BURST_DRAIN:    // removes until empty, then a few on the empty table
                for (int i = 0; i < 19; i++)
                    cmd_q.push_back(make_cmd(OP_REMOVE, 16'($urandom), 1'($urandom), 1'b1));
            BURST_LOCKED:
            begin
                n = $urandom_range(3, 14);
                cmd_q.push_back(make_cmd(OP_LOCK, 16'($urandom), 1'($urandom), 1'b0));
                for (int i = 0; i < n; i++)
                    if ($urandom_range(5) == 0)
                        cmd_q.push_back(mixed_cmd());
                    else
                        cmd_q.push_back(make_cmd(OP_TICK, 16'($urandom), 1'($urandom), 1'b0));
                cmd_q.push_back(make_cmd(OP_UNLOCK, 16'($urandom), 1'($urandom), 1'b0));
            end
            BURST_NOISE:
                for (int i = 0; i < 10; i++)
                    cmd_q.push_back(make_cmd(3'($urandom), 16'($urandom), 1'($urandom),
                                             1'b0));
            BURST_SATURATE: // locked long enough for the quantum to pin at its floor
            begin
                for (int i = 0; i < 3; i++)
                    cmd_q.push_back(make_cmd(OP_ADD, fresh_id(), 1'b0, 1'b0));
                cmd_q.push_back(make_cmd(OP_LOCK, 16'h0000, 1'b0, 1'b0));
                for (int i = 0; i < 262; i++)
                    cmd_q.push_back(make_cmd(OP_TICK, 16'($urandom), 1'($urandom), 1'b0));
                cmd_q.push_back(make_cmd(OP_UNLOCK, 16'h0000, 1'b0, 1'b0));
            end
            default:
                for (int i = 0; i < 30; i++)
                    cmd_q.push_back(mixed_cmd());
        endcase
    endtask

    function automatic burst_t pick_burst();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45) return BURST_MIXED;
        if (r < 60) return BURST_FILL;
        if (r < 72) return BURST_DRAIN;
        if (r < 87) return BURST_LOCKED;
        return BURST_NOISE;
    endfunction

    // Offer one word and hold it until taken. Entered at a clock edge; the
    // valid is lowered only for a gap, so it never drops and rises in one step.
    task automatic send_word(input cmd_t c);
        reply_t res;
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        if (c.pick_held)
            c.id = held_task_id();
        s_tdata  <= {7'b0, c.run, c.id};
        s_tuser  <= c.op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        schedule_step(c.op, c.id, c.run, res);
        expected_q.push_back(c.typed ? c.want : res);
        words_sent++;
    endtask

    task automatic drain_cmds();
        cmd_t c;
        while (cmd_q.size() != 0)
        begin
            c = cmd_q.pop_front();
            send_word(c);
        end
    endtask

    // Quiet point: every result back, then the block is idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reload(input logic [7:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        reload_val = v;
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // Result check: oldest expectation against each accepted result word.
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status    = status_t'(m_tuser);
            got.cur_id    = m_tdata[15:0];
            got.cur_valid = m_tdata[16];
            got.switched  = m_tdata[17];
            words_seen++;
            if (expected_q.size() == 0)
            begin
                error_count++;
                if (error_count <= SHOW_ERRORS)
                    $display("[%0t] unexpected result: status %0d id %h valid %b sw %b",
                             $realtime, got.status, got.cur_id, got.cur_valid, got.switched);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= SHOW_ERRORS)
                        $display("[%0t] result %0d: exp st %0d id %h v %b sw %b, got st %0d id %h v %b sw %b",
                                 $realtime, words_seen, want.status, want.cur_id,
                                 want.cur_valid, want.switched, got.status, got.cur_id,
                                 got.cur_valid, got.switched);
                end
            end
        end
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase_start;
        // Directed rows: hand-typed results only where plain from the spec
        // (empty table, spare ops, lock, unlock, first adds, misses); the rest are predicted.
        directed_plan = '{
            '{OP_TICK,   16'h0000, 1'b0, 1'b0, 1'b1, '{ST_EMPTY,    16'h0000, 1'b0, 1'b0}},
            '{OP_REMOVE, 16'h1234, 1'b0, 1'b0, 1'b1, '{ST_EMPTY,    16'h0000, 1'b0, 1'b0}},
            '{OP_SETRUN, 16'hFFFF, 1'b1, 1'b0, 1'b1, '{ST_EMPTY,    16'h0000, 1'b0, 1'b0}},
            '{OP_SPARE6, 16'hFFFF, 1'b1, 1'b0, 1'b1, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_SPARE7, 16'h0000, 1'b0, 1'b0, 1'b1, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_LOCK,   16'h0000, 1'b0, 1'b0, 1'b1, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_UNLOCK, 16'h0000, 1'b0, 1'b0, 1'b1, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_ADD,    16'hFFFF, 1'b1, 1'b0, 1'b1, '{ST_OK,       16'hFFFF, 1'b1, 1'b0}},
            '{OP_ADD,    16'h0000, 1'b0, 1'b0, 1'b1, '{ST_OK,       16'hFFFF, 1'b1, 1'b0}},
            '{OP_ADD,    16'hA5A5, 1'b1, 1'b0, 1'b1, '{ST_OK,       16'hFFFF, 1'b1, 1'b0}},
            '{OP_ADD,    16'h5A5A, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_SETRUN, 16'h0000, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_SETRUN, 16'hBEEF, 1'b1, 1'b0, 1'b1, '{ST_NOTFOUND, 16'hFFFF, 1'b1, 1'b0}},
            '{OP_REMOVE, 16'hBEEF, 1'b0, 1'b0, 1'b1, '{ST_NOTFOUND, 16'hFFFF, 1'b1, 1'b0}},
            '{OP_TICK,   16'h0000, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_TICK,   16'h0000, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_TICK,   16'h0000, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_TICK,   16'h0000, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_TICK,   16'h0000, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_LOCK,   16'h0000, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_TICK,   16'h0000, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_TICK,   16'h0000, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_UNLOCK, 16'h0000, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_REMOVE, 16'hFFFF, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}},
            '{OP_TICK,   16'h0000, 1'b0, 1'b0, 1'b0, '{ST_OK,       16'h0000, 1'b0, 1'b0}}
        };

        // shadow reset
        for (int i = 0; i < N_SLOTS; i++)
        begin
            ring_next[i]  = '0;
            slot_task[i]  = '0;
            slot_busy[i]  = 1'b0;
            slot_ready[i] = 1'b0;
        end
        cur_slot    = '0;
        held_count  = '0;
        free_slot   = '0;
        reload_val  = RELOAD_RESET;
        quantum     = $signed({1'b0, RELOAD_RESET});
        is_locked   = 1'b0;
        switch_owed = 1'b0;
        id_pool     = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE, 16'($urandom), 16'($urandom)};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, sender 32% idle, receiver 64%
        foreach (directed_plan[i])
            cmd_q.push_back(directed_plan[i]);
        drain_cmds();
        settle();

        for (int phase = 1; phase <= LAST_PHASE; phase++)
        begin
            case (phase)
                1:       write_reload(8'd0);
                2:       write_reload(8'd255);
                3:       write_reload(8'($urandom_range(1, 6)));
                4:       write_reload(8'd2);
                default: write_reload(8'($urandom_range(0, 3)));
            endcase
            // idling: A in phases 0-1, swapped in 2-3, none in 4-5
            if (phase >= 4)
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            else if (phase >= 2)
            begin
                send_gap_pct = 64;
                recv_gap_pct = 32;
            end
            id_pool[4] = 16'($urandom);
            id_pool[5] = 16'($urandom);
            // receiver stalls long while the sender keeps offering: input backs up
            if (phase == 4)
                hold_req = 1'b1;
            phase_start = words_sent;
            if (phase == 1)
                build_burst(BURST_SATURATE);
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                if (cmd_q.size() == 0)
                    build_burst(pick_burst());
                drain_cmds();
            end
            settle();
        end

        repeat (64) @(posedge clk);
        $display("Run: %0d command words, %0d results checked, %0d ring switches",
                 words_sent, words_seen, n_switch);
        $display("Statuses: %0d full, %0d deferred, %0d not found, %0d empty; %0d errors",
                 n_full, n_defer, n_notfound, n_empty, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
